// ===== sv/sisb_pkg.sv =====
package sisb_pkg;

    // Field widths fixed by the record layout.
    localparam int IDX_W = 16;
    localparam int POS_W = 20;
    localparam int CNT_W = 21;
    localparam int QPC_W = 17;

    // Bond positions wrap at MAX_BONDS and run lengths saturate there.
    localparam logic [POS_W-1:0] POS_LAST  = 20'hFFFFF;
    localparam logic [CNT_W-1:0] MAX_BONDS = 21'h100000;

    // Reset value of the query-point count register.
    localparam logic [QPC_W-1:0] QPC_RESET = 17'h10000;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // One bond beat on the input channel.
    typedef struct packed {
        logic [IDX_W-1:0] query_index;
        logic             last_bond;
    } bond_beat_t;

    // One segment record on the result channel.
    typedef struct packed {
        logic [IDX_W-1:0] segment_index;
        logic [POS_W-1:0] segment_start;
        logic [CNT_W-1:0] segment_count;
        logic             index_out_of_range;
        logic             last_record;
    } seg_rec_t;

    // One queue entry: the records that a single bond closes, in order.
    typedef struct packed {
        logic     has_change;
        seg_rec_t change_rec;
        logic     has_last;
        seg_rec_t last_rec;
    } seg_entry_t;

endpackage

// ===== sv/sisb_front.sv =====
module sisb_front
    import sisb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bond_beat_t       s_beat,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [QPC_W-1:0] cfg_data,
    output logic             push_o,
    output seg_entry_t       entry_o,
    input  logic             full_i
);

    logic             run_active_reg, run_active_next;
    logic [IDX_W-1:0] run_index_reg, run_index_next;
    logic [POS_W-1:0] run_start_reg, run_start_next;
    logic [CNT_W-1:0] run_length_reg, run_length_next;
    logic [POS_W-1:0] bond_pos_reg, bond_pos_next;
    logic [QPC_W-1:0] qpc_reg;

    logic             accept;
    logic             change;
    logic [IDX_W-1:0] cur_index;
    logic [POS_W-1:0] cur_start;
    logic [CNT_W-1:0] cur_length;
    logic [POS_W-1:0] pos_inc;

    assign s_ready   = !full_i;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // The open run closes when a bond carries a different index.
    assign change = run_active_reg && (s_beat.query_index != run_index_reg);

    // Run as it stands after this bond is counted.
    always_comb begin
        if (!run_active_reg || change) begin
            cur_index  = s_beat.query_index;
            cur_start  = bond_pos_reg;
            cur_length = CNT_W'(1);
        end else begin
            cur_index  = run_index_reg;
            cur_start  = run_start_reg;
            cur_length = (run_length_reg < MAX_BONDS) ? run_length_reg + CNT_W'(1)
                                                      : run_length_reg;
        end
        pos_inc = (bond_pos_reg == POS_LAST) ? '0 : bond_pos_reg + POS_W'(1);
    end

    // Records closed by this bond: the change record first, then the final one.
    always_comb begin
        entry_o.has_change                    = change;
        entry_o.change_rec.segment_index      = run_index_reg;
        entry_o.change_rec.segment_start      = run_start_reg;
        entry_o.change_rec.segment_count      = run_length_reg;
        entry_o.change_rec.index_out_of_range = {1'b0, run_index_reg} >= qpc_reg;
        entry_o.change_rec.last_record        = 1'b0;
        entry_o.has_last                      = s_beat.last_bond;
        entry_o.last_rec.segment_index        = cur_index;
        entry_o.last_rec.segment_start        = cur_start;
        entry_o.last_rec.segment_count        = cur_length;
        entry_o.last_rec.index_out_of_range   = {1'b0, cur_index} >= qpc_reg;
        entry_o.last_rec.last_record          = 1'b1;
        push_o = accept && (change || s_beat.last_bond);
    end

    // Run state update; the final bond returns everything to zero.
    always_comb begin
        run_active_next = run_active_reg;
        run_index_next  = run_index_reg;
        run_start_next  = run_start_reg;
        run_length_next = run_length_reg;
        bond_pos_next   = bond_pos_reg;
        if (accept) begin
            if (s_beat.last_bond) begin
                run_active_next = 1'b0;
                run_index_next  = '0;
                run_start_next  = '0;
                run_length_next = '0;
                bond_pos_next   = '0;
            end else begin
                run_active_next = 1'b1;
                run_index_next  = cur_index;
                run_start_next  = cur_start;
                run_length_next = cur_length;
                bond_pos_next   = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_active_reg <= 1'b0;
            run_index_reg  <= '0;
            run_start_reg  <= '0;
            run_length_reg <= '0;
            bond_pos_reg   <= '0;
            qpc_reg        <= QPC_RESET;
        end else begin
            run_active_reg <= run_active_next;
            run_index_reg  <= run_index_next;
            run_start_reg  <= run_start_next;
            run_length_reg <= run_length_next;
            bond_pos_reg   <= bond_pos_next;
            if (cfg_valid && cfg_ready) begin
                qpc_reg <= cfg_data;
            end
        end
    end

    // An open run always holds at least one bond.
    a_active_len: assert property (@(posedge aclk) disable iff (!aresetn)
        run_active_reg |-> (run_length_reg != '0))
        else $error("open run with zero length");

    // A change record is never produced without an open run.
    a_change_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_o && entry_o.has_change) |-> run_active_reg)
        else $error("change record without an open run");

    // The final bond always leaves the run state cleared.
    a_last_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_beat.last_bond) |=> (!run_active_reg && bond_pos_reg == '0))
        else $error("run state not cleared after final bond");

endmodule

// ===== sv/sisb_queue.sv =====
module sisb_queue
    import sisb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_i,
    input  seg_entry_t push_entry_i,
    output logic       full_o,
    input  logic       pop_i,
    output logic       empty_o,
    output seg_entry_t head_o
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

    seg_entry_t           store_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full_o  = (count_reg == CNT_FULL);
    assign empty_o = (count_reg == '0);
    assign head_o  = store_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W_Q'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W_Q'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry_i;
        end
    end

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("push into full queue");

    // The fill count stays within the depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    // Every queued entry carries at least one record.
    a_entry_used: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> (push_entry_i.has_change || push_entry_i.has_last))
        else $error("queued entry with no record");

endmodule

// ===== sv/sisb_back.sv =====
module sisb_back
    import sisb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       empty_i,
    input  seg_entry_t head_i,
    output logic       pop_o,
    output logic       m_valid,
    input  logic       m_ready,
    output seg_rec_t   m_beat
);

    logic     m_valid_reg, m_valid_next;
    seg_rec_t m_beat_reg, m_beat_next;
    logic     phase_reg, phase_next;
    logic     load;

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    // The output register takes a new record whenever it is empty or drains.
    assign load = !empty_i && (!m_valid_reg || m_ready);

    // Pick the next record of the head entry; pop once its last record leaves.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_beat_next  = m_beat_reg;
        phase_next   = phase_reg;
        pop_o        = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            if (head_i.has_change && !phase_reg) begin
                m_beat_next = head_i.change_rec;
                if (head_i.has_last) begin
                    phase_next = 1'b1;
                end else begin
                    pop_o = 1'b1;
                end
            end else begin
                m_beat_next = head_i.last_rec;
                phase_next  = 1'b0;
                pop_o       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    // Record payload needs no reset.
    always_ff @(posedge aclk) begin
        m_beat_reg <= m_beat_next;
    end

    // Midway through an entry its final record is still waiting at the head.
    a_phase_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (!empty_i && head_i.has_last && head_i.has_change))
        else $error("second record missing at queue head");

    // After a change record of a two-record entry, the final record follows.
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && phase_reg) |=> (m_valid_reg && m_beat_reg.last_record))
        else $error("final record did not follow change record");

    // A stalled record is held in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_beat_reg)))
        else $error("stalled record changed");

endmodule

// ===== sv/sorted_index_segment_builder_top.sv =====
// Channel    | Direction | Beat                  | Handshake
// s_         | in        | bond_beat_t           | s_valid / s_ready
// m_         | out       | seg_rec_t             | m_valid / m_ready
// cfg_       | in        | query_point_count[16:0] | cfg_valid / cfg_ready (always ready)
//
// One bond beat is accepted per cycle while the queue has room; the front
// classifies it in the cycle of acceptance and queues the records it closes.
// The back drives one record per cycle from its output register while m_ready
// holds, so a bond that closes two runs yields two output beats; results pass
// through the queue and then the output register. The queue depth sets how
// long the output may stall before s_ready falls. Reset clears the run state
// and the queue and loads the count register with 65536; no clearing pass.
module sorted_index_segment_builder_top
    import sisb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bond_beat_t       s_beat,
    output logic             m_valid,
    input  logic             m_ready,
    output seg_rec_t         m_beat,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [QPC_W-1:0] cfg_data
);

    logic       push;
    seg_entry_t push_entry;
    logic       full;
    logic       pop;
    logic       empty;
    seg_entry_t head;

    // Front: run tracking and record classification.
    sisb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push_o    (push),
        .entry_o   (push_entry),
        .full_i    (full)
    );

    // Queue between front and back.
    sisb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_i       (push),
        .push_entry_i (push_entry),
        .full_o       (full),
        .pop_i        (pop),
        .empty_o      (empty),
        .head_o       (head)
    );

    // Back: serializes queued records onto the result channel.
    sisb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty_i (empty),
        .head_i  (head),
        .pop_o   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

endmodule

// ===== tb/sorted_index_segment_builder_top_tb.sv =====
module sorted_index_segment_builder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sisb_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int PENDING_DEPTH  = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASE_BONDS    = 255;
    localparam logic [IDX_W-1:0] IDX_TOP = 16'hFFFF;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    bond_beat_t       s_beat    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    seg_rec_t         m_beat;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [QPC_W-1:0] cfg_data  = '0;

    // Bonds waiting for the driver and segment records waiting for the block.
    bond_beat_t pending_bonds[$];
    seg_rec_t   expected_segments[$];

    int bonds_queued      = 0;
    int bonds_offered     = 0;
    int bonds_accepted    = 0;
    int mismatch_count    = 0;
    int sender_idle_pct   = 26;
    int receiver_idle_pct = 64;
    int pressure_requests = 0;
    int pressure_served   = 0;
    int hold_left         = 0;

    // Predictor state: the open run, the bond position and the count register.
    logic             run_open  = 1'b0;
    logic [IDX_W-1:0] run_idx   = '0;
    logic [POS_W-1:0] run_first = '0;
    logic [CNT_W-1:0] run_len   = '0;
    logic [POS_W-1:0] bond_pos  = '0;
    logic [QPC_W-1:0] point_count = QPC_RESET;

    sorted_index_segment_builder_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Builds the record that closes the open run.
    function automatic seg_rec_t close_record(input logic last);
        seg_rec_t rec;
        rec.segment_index      = run_idx;
        rec.segment_start      = run_first;
        rec.segment_count      = run_len;
        rec.index_out_of_range = ({1'b0, run_idx} >= point_count);
        rec.last_record        = last;
        return rec;
    endfunction

    // Advances the run tracker by one bond and queues the records it closes.
    task automatic predict_segments(input bond_beat_t beat);
        if (run_open && beat.query_index != run_idx) begin
            expected_segments.push_back(close_record(1'b0));
            run_open = 1'b0;
        end
        if (!run_open) begin
            run_open  = 1'b1;
            run_idx   = beat.query_index;
            run_first = bond_pos;
            run_len   = 1;
        end else if (run_len < MAX_BONDS) begin
            run_len = run_len + 1'b1;
        end
        // The position is exactly 20 bits wide, so it wraps at MAX_BONDS by itself.
        bond_pos = bond_pos + 1'b1;
        if (beat.last_bond) begin
            expected_segments.push_back(close_record(1'b1));
            run_open  = 1'b0;
            run_idx   = '0;
            run_first = '0;
            run_len   = '0;
            bond_pos  = '0;
        end
    endtask

    task automatic check_segment(input seg_rec_t got);
        seg_rec_t want;
        if (expected_segments.size() == 0) begin
            report_mismatch($sformatf("record with none expected: index %0d start %0d count %0d",
                                      got.segment_index, got.segment_start, got.segment_count));
        end else begin
            want = expected_segments.pop_front();
            if (got.segment_index !== want.segment_index)
                report_mismatch($sformatf("segment_index %0d, expected %0d",
                                          got.segment_index, want.segment_index));
            if (got.segment_start !== want.segment_start)
                report_mismatch($sformatf("segment_start %0d, expected %0d",
                                          got.segment_start, want.segment_start));
            if (got.segment_count !== want.segment_count)
                report_mismatch($sformatf("segment_count %0d, expected %0d",
                                          got.segment_count, want.segment_count));
            if (got.index_out_of_range !== want.index_out_of_range)
                report_mismatch($sformatf("index_out_of_range %b, expected %b",
                                          got.index_out_of_range, want.index_out_of_range));
            if (got.last_record !== want.last_record)
                report_mismatch($sformatf("last_record %b, expected %b",
                                          got.last_record, want.last_record));
        end
    endtask

    // Monitor: every handshake is taken from the values present at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                point_count = cfg_data;
            if (s_valid && s_ready) begin
                predict_segments(s_beat);
                bonds_accepted++;
            end
            if (m_valid && m_ready)
                check_segment(m_beat);
        end
    end

    // Driver: a new bond is offered only once the previous beat has been taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || bonds_accepted == bonds_offered) begin
            if (pending_bonds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_beat  <= pending_bonds.pop_front();
                s_valid <= 1'b1;
                bonds_offered++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, and now and then a long hold-off that backs up the block.
    always @(negedge aclk) begin
        if (pressure_requests != pressure_served) begin
            pressure_served = pressure_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic push_bond(input logic [IDX_W-1:0] idx, input logic last);
        bond_beat_t beat;
        beat.query_index = idx;
        beat.last_bond   = last;
        while (pending_bonds.size() >= PENDING_DEPTH)
            @(negedge aclk);
        pending_bonds.push_back(beat);
        bonds_queued++;
    endtask

    // Waits until every bond is in and every record is out, then lets the block settle.
    task automatic wait_until_idle();
        while (bonds_accepted != bonds_queued || expected_segments.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_point_count(input logic [QPC_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Index picker: often near the count boundary, else below the count, across the full range or at the extremes.
    function automatic logic [IDX_W-1:0] pick_index(input logic [QPC_W-1:0] count);
        int r;
        int c;
        int v;
        r = $urandom_range(99);
        c = count;
        if (r < 40)
            v = c - 3 + $urandom_range(6);
        else if (r < 70)
            v = $urandom_range(c);
        else if (r < 90)
            v = $urandom_range(65535);
        else
            v = $urandom_range(1) ? 65535 : 0;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[IDX_W-1:0];
    endfunction

    // Random lists: mostly sorted with random run lengths, some unsorted, some left open.
    task automatic queue_random_phase(input int n_items, input logic [QPC_W-1:0] count,
                                      input bit close_at_end);
        int left;
        int kind;
        int list_len;
        int step;
        int v;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] prev_run;
        logic last;
        left = n_items;
        prev_run = '0;
        while (left > 0) begin
            kind = $urandom_range(99);
            list_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            if (list_len > left)
                list_len = left;
            idx = ($urandom_range(3) == 0) ? '0 : pick_index(count);
            for (int k = 0; k < list_len; k++) begin
                v = idx;
                if (kind < 70) begin
                    // Sorted: stay on the run, step up a little, or jump ahead.
                    step = $urandom_range(99);
                    if (k != 0 && step < 35)
                        v = idx + $urandom_range(3, 1);
                    else if (k != 0 && step < 45)
                        v = $urandom_range(65535, idx);
                end else begin
                    // Unsorted: drop back to zero, revisit an old index, or wander.
                    case ($urandom_range(3))
                        0: v = 0;
                        1: v = prev_run;
                        2: v = pick_index(count);
                        default: v = idx;
                    endcase
                end
                if (v > 65535)
                    v = 65535;
                if (v != idx)
                    prev_run = idx;
                idx = v[IDX_W-1:0];
                if (kind >= 90)
                    last = ($urandom_range(29) == 0);
                else
                    last = (k == list_len - 1) || (kind >= 70 && $urandom_range(19) == 0);
                if (left == 1)
                    last = close_at_end;
                push_bond(idx, last);
                left--;
            end
        end
    endtask

    task automatic run_phase(input logic [QPC_W-1:0] count, input bit close_at_end,
                             input bit hold_off);
        write_point_count(count);
        if (hold_off)
            pressure_requests++;
        queue_random_phase(PHASE_BONDS, count, close_at_end);
        wait_until_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: one run closed by the last bond.
        push_bond(16'd0, 1'b0);
        push_bond(16'd0, 1'b0);
        push_bond(16'd0, 1'b1);
        // A list of a single bond at the top index.
        push_bond(IDX_TOP, 1'b1);
        // Sorted runs ending at the top index.
        push_bond(16'd1, 1'b0);
        push_bond(16'd1, 1'b0);
        push_bond(16'd2, 1'b0);
        push_bond(16'd5, 1'b0);
        push_bond(16'd5, 1'b0);
        push_bond(16'd5, 1'b0);
        push_bond(IDX_TOP, 1'b1);
        // Unsorted: a return to zero and an index seen before.
        push_bond(16'd7, 1'b0);
        push_bond(16'd3, 1'b0);
        push_bond(16'd3, 1'b0);
        push_bond(16'd0, 1'b0);
        push_bond(16'd7, 1'b0);
        push_bond(16'd0, 1'b1);
        // The last bond also changes the index, so one bond closes two runs.
        push_bond(16'd4, 1'b0);
        push_bond(16'd9, 1'b1);
        // Alternating bit patterns.
        push_bond(16'hAAAA, 1'b0);
        push_bond(16'h5555, 1'b1);
        wait_until_idle();

        // Sender idles lightly while the receiver stalls heavily.
        run_phase(17'd1, 1'b1, 1'b0);
        run_phase(17'd0, 1'b0, 1'b1);
        run_phase(17'h1FFFF, 1'b1, 1'b0);

        // The other way round.
        sender_idle_pct   = 64;
        receiver_idle_pct = 26;
        run_phase(17'd65535, 1'b0, 1'b0);
        run_phase(17'($urandom_range(300, 2)), 1'b1, 1'b0);
        run_phase(QPC_RESET, 1'b0, 1'b0);

        // No idling on either side.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_phase(17'($urandom_range(65536, 1)), 1'b1, 1'b1);

        if (mismatch_count == 0)
            $display("sorted_index_segment_builder_top_tb: PASS");
        else
            $display("sorted_index_segment_builder_top_tb: FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("sorted_index_segment_builder_top_tb: FAIL");
        $finish;
    end

endmodule
